[rtl/adx_pkg.sv]
// Package with the shared constants and types of the ADX ADPCM decoder.
package adx_pkg;

  localparam int FRAME_BYTES  = 18;
  localparam int POS_W        = 5;
  localparam int SCALE_HI_POS = 0;
  localparam int SCALE_LO_POS = 1;
  localparam int GAIN_W       = 16;
  localparam int GS_W         = 32;
  localparam int NIB_W        = 4;
  localparam int SAMPLE_W     = 16;
  localparam int T1_W         = GS_W + 1 + NIB_W;
  localparam int T2_W         = 32;
  localparam int ACC_W        = T1_W + 2;
  localparam int FRAC_BITS    = 14;
  localparam int SH_W         = ACC_W - FRAC_BITS;

  localparam logic [GAIN_W-1:0]          GAIN_RESET  = 16'd16384;
  localparam logic signed [16:0]         COEF_LAST   = 17'sh07298;
  localparam logic signed [16:0]         COEF_BEFORE = 17'sh03350;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX  = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN  = -16'sh8000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [GS_W-1:0] gs;
    logic [7:0]      data_byte;
    logic            channel;
    logic            frame_end;
  } adx_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_HI,
    BK_ACC_HI,
    BK_MUL_LO,
    BK_ACC_LO
  } back_state_e;

endpackage

[rtl/adx_if.sv]
// Request channel interfaces for the decoder input bytes and output samples.
interface adx_in_if;
  logic       valid;
  logic       ready;
  logic       channel;
  logic [7:0] data_byte;

  modport source (output valid, output channel, output data_byte, input ready);
  modport sink (input valid, input channel, input data_byte, output ready);
endinterface

interface adx_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               sample_channel;
  logic               pair_last;
  logic               frame_end;

  modport source (output valid, output sample, output sample_channel, output pair_last,
                  output frame_end, input ready);
  modport sink (input valid, input sample, input sample_channel, input pair_last,
                input frame_end, output ready);
endinterface

[rtl/adx_front.sv]
// Front end: tracks frame position and scale per channel and queues data bytes.
module adx_front #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [adx_pkg::GAIN_W-1:0]    gain_i,
  adx_in_if.sink                        byte_i,
  output logic                          push_valid_o,
  output adx_pkg::adx_job_t             push_entry_o,
  input  logic                          push_ready_i
);
  import adx_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [POS_W-1:0] pos_q   [NUM_CHANNELS];
  logic [POS_W-1:0] pos_d   [NUM_CHANNELS];
  logic [15:0]      scale_q [NUM_CHANNELS];
  logic [15:0]      scale_d [NUM_CHANNELS];

  logic [CH_W-1:0]  ch_idx;
  logic             ch_ok;
  logic             accept;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] pos_next;

  assign byte_i.ready = push_ready_i;

  always_comb begin
    ch_idx   = CH_W'(byte_i.channel);
    ch_ok    = int'(byte_i.channel) < NUM_CHANNELS;
    accept   = byte_i.valid && byte_i.ready;
    pos_eff  = (pos_q[ch_idx] >= POS_W'(FRAME_BYTES)) ? '0 : pos_q[ch_idx];
    pos_next = (pos_eff == POS_W'(FRAME_BYTES - 1)) ? '0 : pos_eff + POS_W'(1);
    pos_d    = pos_q;
    scale_d  = scale_q;
    if (accept && ch_ok) begin
      pos_d[ch_idx] = pos_next;
      if (pos_eff == POS_W'(SCALE_HI_POS)) begin
        scale_d[ch_idx][15:8] = byte_i.data_byte;
      end else if (pos_eff == POS_W'(SCALE_LO_POS)) begin
        scale_d[ch_idx][7:0] = byte_i.data_byte;
      end
    end
  end

  always_comb begin
    push_valid_o           = accept && ch_ok && (pos_eff > POS_W'(SCALE_LO_POS));
    push_entry_o.gs        = GS_W'(gain_i) * GS_W'(scale_q[ch_idx]);
    push_entry_o.data_byte = byte_i.data_byte;
    push_entry_o.channel   = byte_i.channel;
    push_entry_o.frame_end = pos_eff == POS_W'(FRAME_BYTES - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pos_q[i]   <= '0;
        scale_q[i] <= '0;
      end
    end else begin
      pos_q   <= pos_d;
      scale_q <= scale_d;
    end
  end

endmodule

[rtl/adx_queue.sv]
// Short queue of decode jobs between the front end and the back end.
module adx_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  adx_pkg::adx_job_t push_entry_i,
  output logic              push_ready_o,
  input  logic              pop_i,
  output logic              pop_valid_o,
  output adx_pkg::adx_job_t pop_entry_o
);
  import adx_pkg::*;

  adx_job_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    push_ready_o = count_q != (QPTR_W + 1)'(QUEUE_DEPTH);
    pop_valid_o  = count_q != '0;
    pop_entry_o  = slot_q[rd_ptr_q];
    do_push      = push_valid_i && push_ready_o;
    do_pop       = pop_i && pop_valid_o;
    wr_ptr_d     = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d     = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d      = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QPTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[rtl/adx_back.sv]
// Back end: decodes the two nibbles of a data byte and holds the output sample.
module adx_back #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  adx_pkg::adx_job_t q_entry_i,
  output logic              pop_o,
  adx_out_if.source         sample_o
);
  import adx_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  back_state_e state_q, state_d;
  adx_job_t    job_q;

  logic signed [T1_W-1:0]     t1_q, t1_d;
  logic signed [T2_W-1:0]     t2_q, t2_d;
  logic signed [T2_W-1:0]     t3_q, t3_d;
  logic signed [SAMPLE_W-1:0] hist_last_q   [NUM_CHANNELS];
  logic signed [SAMPLE_W-1:0] hist_before_q [NUM_CHANNELS];

  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_valid_q, out_valid_d;
  logic                       out_channel_q;
  logic                       out_pair_last_q;
  logic                       out_frame_end_q;

  logic [CH_W-1:0]            ch_idx;
  logic signed [NIB_W-1:0]    nib;
  logic                       out_free;
  logic                       fire;
  logic                       is_lo;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SH_W-1:0]     shifted;
  logic signed [SAMPLE_W-1:0] sat;

  assign sample_o.valid          = out_valid_q;
  assign sample_o.sample         = out_sample_q;
  assign sample_o.sample_channel = out_channel_q;
  assign sample_o.pair_last      = out_pair_last_q;
  assign sample_o.frame_end      = out_frame_end_q;

  assign out_free = !out_valid_q || sample_o.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          state_d = BK_MUL_HI;
        end
      end
      BK_MUL_HI: state_d = BK_ACC_HI;
      BK_ACC_HI: begin
        if (out_free) begin
          state_d = BK_MUL_LO;
        end
      end
      BK_MUL_LO: state_d = BK_ACC_LO;
      BK_ACC_LO: begin
        if (out_free) begin
          state_d = q_valid_i ? BK_MUL_HI : BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    fire  = 1'b0;
    is_lo = 1'b0;
    case (state_q)
      BK_IDLE:   pop_o = q_valid_i;
      BK_MUL_LO: is_lo = 1'b1;
      BK_ACC_HI: fire = out_free;
      BK_ACC_LO: begin
        is_lo = 1'b1;
        fire  = out_free;
        pop_o = out_free && q_valid_i;
      end
      default: pop_o = 1'b0;
    endcase
  end

  always_comb begin
    ch_idx  = CH_W'(job_q.channel);
    nib     = is_lo ? $signed(job_q.data_byte[3:0]) : $signed(job_q.data_byte[7:4]);
    t1_d    = T1_W'($signed({1'b0, job_q.gs})) * T1_W'(nib);
    t2_d    = T2_W'(COEF_LAST) * T2_W'(hist_last_q[ch_idx]);
    t3_d    = T2_W'(COEF_BEFORE) * T2_W'(hist_before_q[ch_idx]);
    acc     = ACC_W'(t1_q) + ACC_W'(t2_q) - ACC_W'(t3_q);
    shifted = $signed(acc[ACC_W-1:FRAC_BITS]);
    if (shifted > SH_W'(SAMPLE_MAX)) begin
      sat = SAMPLE_MAX;
    end else if (shifted < SH_W'(SAMPLE_MIN)) begin
      sat = SAMPLE_MIN;
    end else begin
      sat = shifted[SAMPLE_W-1:0];
    end
    out_valid_d = fire ? 1'b1 : (sample_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    t1_q <= t1_d;
    t2_q <= t2_d;
    t3_q <= t3_d;
    if (pop_o) begin
      job_q <= q_entry_i;
    end
    if (fire) begin
      out_sample_q    <= sat;
      out_channel_q   <= job_q.channel;
      out_pair_last_q <= is_lo;
      out_frame_end_q <= is_lo && job_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        hist_last_q[i]   <= '0;
        hist_before_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        hist_before_q[ch_idx] <= hist_last_q[ch_idx];
        hist_last_q[ch_idx]   <= sat;
      end
    end
  end

endmodule

[rtl/adx_adpcm_decoder.sv]
// ADX ADPCM decoder: takes one frame byte per request and returns 16-bit PCM samples.
// Each request carries a channel and the next byte of that channel's 18-byte frame. The two
// scale bytes of a frame are absorbed by the front end and produce no sample; each data
// byte produces two sample requests, high nibble first. The back-end sequencer handles a data
// byte as a multiply step and an accumulate-and-saturate step per nibble, the second nibble
// waiting for the history that the first one writes, and takes the next data byte only after
// both nibbles of the last one are done. A two-entry job queue sits between front and back,
// and a registered output stage lets decoding continue until a sample waits unread.
// The gain register may only be written while no request is in flight.
module adx_adpcm_decoder #(
  parameter int NUM_CHANNELS = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [adx_pkg::GAIN_W-1:0] cfg_wdata_i,
  adx_in_if.sink                     byte_i,
  adx_out_if.source                  sample_o
);
  import adx_pkg::*;

  logic [GAIN_W-1:0] gain_q;
  logic              push_valid;
  logic              push_ready;
  adx_job_t          push_entry;
  logic              q_valid;
  adx_job_t          q_entry;
  logic              pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  adx_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gain_i       (gain_q),
    .byte_i       (byte_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  adx_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (q_valid),
    .pop_entry_o  (q_entry)
  );

  adx_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .pop_o     (pop),
    .sample_o  (sample_o)
  );

  a_push_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> push_ready)
    else $error("front end pushed a job into a full queue");

  a_pop_has_job : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("back end took a job from an empty queue");

  a_frame_end_on_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_o.valid && sample_o.frame_end |-> sample_o.pair_last)
    else $error("frame end flagged on a high-nibble sample");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the ADX ADPCM decoder with its own sample predictor.
module testbench;

  localparam int     CHANNELS        = 2;
  localparam int     BYTES_PER_FRAME = 18;
  localparam longint LAST_WEIGHT     = 64'sh7298;
  localparam longint BEFORE_WEIGHT   = 64'sh3350;
  localparam int     FRAC_SHIFT      = 14;
  localparam int     PHASE_ITEMS     = 172;
  localparam int     SETTLE_CYCLES   = 16;
  localparam int     IDLE_LIMIT      = 2000;

  localparam logic [18*8-1:0] DIRECTED_FRAME = {
    8'hFF, 8'hFF, 8'h77, 8'h77, 8'h88, 8'h88, 8'h80, 8'h08, 8'h00,
    8'hFF, 8'h7F, 8'hF7, 8'h01, 8'h10, 8'h9A, 8'hC3, 8'h5E, 8'h24
  };
  localparam logic [8*8-1:0] EDGE_BYTES = {
    8'h00, 8'hFF, 8'h77, 8'h88, 8'h7F, 8'hF8, 8'h80, 8'h08
  };

  typedef struct packed {
    logic       channel;
    logic [7:0] data_byte;
  } frame_byte_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               sample_channel;
    logic               pair_last;
    logic               frame_end;
  } pcm_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [adx_pkg::GAIN_W-1:0] cfg_wdata_i;

  adx_in_if  byte_if ();
  adx_out_if sample_if ();

  adx_adpcm_decoder #(
    .NUM_CHANNELS(CHANNELS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .byte_i     (byte_if),
    .sample_o   (sample_if)
  );

  frame_byte_t        bytes_pending[$];
  pcm_result_t        samples_due[$];
  pcm_result_t        oldest_due;
  logic [15:0]        gain_q;
  logic [4:0]         position_q[CHANNELS];
  logic [15:0]        scale_q[CHANNELS];
  logic signed [15:0] last_q[CHANNELS];
  logic signed [15:0] before_q[CHANNELS];
  int                 error_count = 0;
  int                 burst_left;
  int                 gap_left;
  rx_mode_e           rx_mode;
  int                 rx_left;
  logic [4:0]         rx_phase;
  int                 idle_cycles;

  function automatic logic signed [15:0] pcm_from_nibble(input logic ch, input logic [3:0] nib);
    longint             acc;
    logic signed [15:0] pcm;
    acc = longint'(gain_q) * longint'($signed(nib)) * longint'(scale_q[ch])
        + LAST_WEIGHT * longint'(last_q[ch]) - BEFORE_WEIGHT * longint'(before_q[ch]);
    acc = acc >>> FRAC_SHIFT;
    if (acc > 32767) begin
      pcm = 16'sh7FFF;
    end else if (acc < -32768) begin
      pcm = 16'sh8000;
    end else begin
      pcm = acc[15:0];
    end
    before_q[ch] = last_q[ch];
    last_q[ch]   = pcm;
    return pcm;
  endfunction

  task automatic predict_byte(input frame_byte_t req);
    logic [4:0]  pos;
    pcm_result_t hi;
    pcm_result_t lo;
    pos = position_q[req.channel];
    position_q[req.channel] = (pos == BYTES_PER_FRAME - 1) ? 5'd0 : pos + 5'd1;
    if (pos == 0) begin
      scale_q[req.channel][15:8] = req.data_byte;
    end else if (pos == 1) begin
      scale_q[req.channel][7:0] = req.data_byte;
    end else begin
      hi.sample         = pcm_from_nibble(req.channel, req.data_byte[7:4]);
      hi.sample_channel = req.channel;
      hi.pair_last      = 1'b0;
      hi.frame_end      = 1'b0;
      lo.sample         = pcm_from_nibble(req.channel, req.data_byte[3:0]);
      lo.sample_channel = req.channel;
      lo.pair_last      = 1'b1;
      lo.frame_end      = (pos == BYTES_PER_FRAME - 1);
      samples_due.push_back(hi);
      samples_due.push_back(lo);
    end
  endtask

  task automatic queue_byte(input logic ch, input logic [7:0] value);
    frame_byte_t req;
    req.channel   = ch;
    req.data_byte = value;
    bytes_pending.push_back(req);
  endtask

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // The sender pauses here until every request has been taken and every sample has come.
  task automatic wait_quiet();
    while (bytes_pending.size() != 0 || samples_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid     <= 1'b0;
      byte_if.channel   <= 1'b0;
      byte_if.data_byte <= '0;
      burst_left        <= 0;
      gap_left          <= 0;
    end else if (!byte_if.valid || byte_if.ready) begin
      if (byte_if.valid) begin
        predict_byte(bytes_pending.pop_front());
      end
      if (gap_left != 0) begin
        gap_left      <= gap_left - 1;
        byte_if.valid <= 1'b0;
      end else if (bytes_pending.size() != 0) begin
        byte_if.valid     <= 1'b1;
        byte_if.channel   <= bytes_pending[0].channel;
        byte_if.data_byte <= bytes_pending[0].data_byte;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        byte_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_if.ready <= 1'b0;
      rx_mode         <= RX_OPEN;
      rx_left         <= 0;
      rx_phase        <= '0;
    end else begin
      rx_phase <= rx_phase + 5'd1;
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
        rx_left <= $urandom_range(8, 120);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   sample_if.ready <= 1'b1;
        RX_COIN:   sample_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: sample_if.ready <= ($urandom_range(0, 5) == 0);
        default:   sample_if.ready <= (rx_phase < 5'd9);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && sample_if.valid && sample_if.ready) begin
      if (samples_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected sample %0d on channel %0d",
                                sample_if.sample, sample_if.sample_channel));
      end else begin
        oldest_due = samples_due.pop_front();
        if (sample_if.sample !== oldest_due.sample) begin
          flag_mismatch($sformatf("sample %0d, predicted %0d",
                                  sample_if.sample, oldest_due.sample));
        end
        if (sample_if.sample_channel !== oldest_due.sample_channel) begin
          flag_mismatch($sformatf("sample_channel %b, predicted %b",
                                  sample_if.sample_channel, oldest_due.sample_channel));
        end
        if (sample_if.pair_last !== oldest_due.pair_last) begin
          flag_mismatch($sformatf("pair_last %b, predicted %b",
                                  sample_if.pair_last, oldest_due.pair_last));
        end
        if (sample_if.frame_end !== oldest_due.frame_end) begin
          flag_mismatch($sformatf("frame_end %b, predicted %b",
                                  sample_if.frame_end, oldest_due.frame_end));
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((byte_if.valid && byte_if.ready) || (sample_if.valid && sample_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic        ch;
    logic [7:0]  value;
    logic [15:0] next_gain;
    int          pick;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    gain_q = adx_pkg::GAIN_RESET;
    for (int c = 0; c < CHANNELS; c++) begin
      position_q[c] = '0;
      scale_q[c]    = '0;
      last_q[c]     = '0;
      before_q[c]   = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Saturation both ways, every nibble extreme, and a second frame after the wrap.
    for (int i = 0; i < BYTES_PER_FRAME; i++) begin
      queue_byte(1'b0, DIRECTED_FRAME[8*(BYTES_PER_FRAME-1-i) +: 8]);
    end
    queue_byte(1'b1, 8'h00);
    queue_byte(1'b1, 8'h01);
    queue_byte(1'b1, 8'h7F);
    queue_byte(1'b0, 8'h80);
    queue_byte(1'b0, 8'h00);
    queue_byte(1'b0, 8'h12);

    ch = 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      wait_quiet();
      case (phase)
        0:       next_gain = 16'hFFFF;
        1:       next_gain = 16'h0000;
        2:       next_gain = 16'h0001;
        3:       next_gain = 16'h8000;
        default: next_gain = 16'($urandom_range(0, 65535));
      endcase
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= next_gain;
      gain_q = next_gain;
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          ch = ~ch;
        end
        if ($urandom_range(0, 3) == 0) begin
          pick  = $urandom_range(0, 7);
          value = EDGE_BYTES[8*pick +: 8];
        end else begin
          value = 8'($urandom_range(0, 255));
        end
        queue_byte(ch, value);
      end
    end

    wait_quiet();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/adx_pkg.sv
rtl/adx_if.sv
rtl/adx_front.sv
rtl/adx_queue.sv
rtl/adx_back.sv
rtl/adx_adpcm_decoder.sv
tb/testbench.sv
